### src/csp_pkg.sv
`default_nettype none

package csp_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [1:0] {
      KIND_CHAR   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2
   } token_kind_type;

   typedef struct packed {
      logic in_quoted;
      logic quote_seen;
      logic field_has_chars;
      logic record_has_fields;
   } parse_state_type;

   typedef struct packed {
      logic           emit;
      token_kind_type kind;
      logic [7:0]     char_out;
   } token_type;

endpackage

`default_nettype wire

### src/csp_step.sv
`default_nettype none

module csp_step
   import csp_pkg::*;
(
   input  wire parse_state_type state_cur,
   input  wire logic [7:0]      data_byte,
   input  wire logic            end_of_input,
   output parse_state_type      state_nxt,
   output token_type            token
);

   always_comb begin
      state_nxt      = state_cur;
      token.emit     = 1'b0;
      token.kind     = KIND_CHAR;
      token.char_out = 8'h00;

      if (end_of_input) begin
         // flush: one record end if anything is pending, then clear everything
         token.emit = state_cur.field_has_chars | state_cur.record_has_fields;
         token.kind = KIND_RECORD;
         state_nxt  = '0;
      end else if (state_cur.in_quoted && state_cur.quote_seen && data_byte == CH_QUOTE) begin
         // doubled quote inside quotes is a literal quote
         state_nxt.quote_seen      = 1'b0;
         state_nxt.field_has_chars = 1'b1;
         token.emit                = 1'b1;
         token.char_out            = CH_QUOTE;
      end else if (state_cur.in_quoted && !state_cur.quote_seen) begin
         if (data_byte == CH_QUOTE) begin
            state_nxt.quote_seen = 1'b1;
         end else begin
            state_nxt.field_has_chars = 1'b1;
            token.emit                = 1'b1;
            token.char_out            = data_byte;
         end
      end else begin
         // unquoted text, or the byte right after a closing quote
         state_nxt.in_quoted  = 1'b0;
         state_nxt.quote_seen = 1'b0;
         case (data_byte)
            CH_QUOTE: begin
               state_nxt.in_quoted = 1'b1;
            end
            CH_COMMA: begin
               state_nxt.field_has_chars   = 1'b0;
               state_nxt.record_has_fields = 1'b1;
               token.emit                  = 1'b1;
               token.kind                  = KIND_FIELD;
            end
            CH_LF: begin
               state_nxt.field_has_chars   = 1'b0;
               state_nxt.record_has_fields = 1'b0;
               token.emit                  = 1'b1;
               token.kind                  = KIND_RECORD;
            end
            CH_CR: begin
               token.emit = 1'b0;
            end
            default: begin
               state_nxt.field_has_chars = 1'b1;
               token.emit                = 1'b1;
               token.char_out            = data_byte;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### src/csv_stream_parser_core.sv
// A request accepted into the input register has its token on rsp_ once it moves on into
// the result register; requests that make no token produce nothing on rsp_.
// Throughput: one request per cycle while rsp_ is not stalled; the parser state update
// is a single small decode between the input register and the result register.
// Reset: synchronous, active high; clears the parse state and both valid flags.
`default_nettype none

module csv_stream_parser_core
   import csp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_input,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_token_kind,
   output logic [7:0]      rsp_char_out
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_end_ff;
   parse_state_type state_ff, state_in;
   token_type       token;
   logic            out_valid_ff, out_valid_in;
   logic [1:0]      out_kind_ff;
   logic [7:0]      out_char_ff;
   logic            advance;

   csp_step u_step (
      .state_cur    (state_ff),
      .data_byte    (in_byte_ff),
      .end_of_input (in_end_ff),
      .state_nxt    (state_in),
      .token        (token)
   );

   // the held request moves on once the result register is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff & ~rsp_ready;
      if (advance) begin
         out_valid_in = token.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_end_of_input;
      end
      if (advance && token.emit) begin
         out_kind_ff <= token.kind;
         out_char_ff <= token.char_out;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_token_kind = out_kind_ff;
   assign rsp_char_out   = out_char_ff;

endmodule

`default_nettype wire

### src/csp_checker.sv
`default_nettype none

module csp_checker
   import csp_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_data_byte,
   input wire logic       req_end_of_input,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_token_kind,
   input wire logic [7:0] rsp_char_out
);

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte)
         && $stable(req_end_of_input))
      else $error("stalled request changed");

   // a stalled token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_char_out))
      else $error("stalled token changed");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_CHAR |-> rsp_char_out == 8'h00)
      else $error("nonzero char on field or record end");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind == KIND_CHAR || rsp_token_kind == KIND_FIELD
         || rsp_token_kind == KIND_RECORD)
      else $error("illegal token kind");

   // no token can appear before any request has gone through
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("token right after reset");

endmodule

bind csv_stream_parser_core csp_checker u_csp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_data_byte    (req_data_byte),
   .req_end_of_input (req_end_of_input),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_char_out     (rsp_char_out)
);

`default_nettype wire
